// File: hw/rtl/lfst_pkg.sv
// lfst_pkg: shared types and constants of the lowest-free slot table
// used by lfst_scan, lfst_store, lowest_free_slot_table_core and lfst_checker
package lfst_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int VALUE_W     = 31;
  localparam int POS_W       = 6;
  localparam int IDX_W       = 6;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int ROW_SH      = 3;
  localparam int ROW_BITS    = 1 << ROW_SH;
  localparam int CMP_W       = 16;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_POP = 1'b1
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic used_we;
    logic val_we;
  } mem_ctl_t;

endpackage

// File: hw/rtl/lfst_scan.sv
// lfst_scan: shared free-slot search over one row of used bits
// depends on lfst_pkg
module lfst_scan import lfst_pkg::*; (
  input  logic [ROW_BITS-1:0] used_i,
  input  logic [CMP_W-1:0]    base_i,
  input  logic [CMP_W-1:0]    start_i,
  input  logic [CMP_W-1:0]    limit_i,
  output logic                found_o,
  output logic [CMP_W-1:0]    idx_o,
  output logic [CMP_W-1:0]    next_o,
  output logic                last_o
);

  always_comb begin
    logic [CMP_W-1:0] cand;
    found_o = 1'b0;
    idx_o   = base_i;
    cand    = base_i;
    next_o  = base_i + CMP_W'(ROW_BITS);
    last_o  = (next_o >= limit_i);
    // walk downwards so the lowest free slot wins
    for (int k = ROW_BITS - 1; k >= 0; k--) begin
      cand = base_i + CMP_W'(k);
      if (!used_i[k] && (cand >= start_i) && (cand < limit_i)) begin
        found_o = 1'b1;
        idx_o   = cand;
      end
    end
  end

endmodule

// File: hw/rtl/lfst_store.sv
// lfst_store: handle value memory and row-organised used-bit memory
// depends on lfst_pkg
module lfst_store import lfst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW   = $clog2(SLOTS),
  localparam int ROWS = (SLOTS + ROW_BITS - 1) / ROW_BITS,
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                clk_i,
  input  mem_ctl_t            ctl_i,
  input  logic [RW-1:0]       used_waddr_i,
  input  logic [ROW_BITS-1:0] used_wdata_i,
  input  logic [RW-1:0]       used_raddr_i,
  output logic [ROW_BITS-1:0] used_rdata_o,
  input  logic [IW-1:0]       val_waddr_i,
  input  logic [VALUE_W-1:0]  val_wdata_i,
  input  logic [IW-1:0]       val_raddr_i,
  output logic [VALUE_W-1:0]  val_rdata_o
);

  logic [ROW_BITS-1:0] used_mem [ROWS];
  logic [VALUE_W-1:0]  val_mem  [SLOTS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.used_we) begin
      used_mem[used_waddr_i] <= used_wdata_i;
    end
    used_rdata_o <= used_mem[used_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    val_rdata_o <= val_mem[val_raddr_i];
  end

endmodule

// File: hw/rtl/lowest_free_slot_table_core.sv
// Slot table that puts handles into the lowest free slot and pops them by index. After
// reset the used bits are cleared one row of eight slots per cycle while the input is
// not ready. A pop, a put into a full table, and a put that lands at the high-water mark
// pass from the input beat through the execute and done states to the result beat; a put
// into a gap also searches each further row of eight used bits up to the high-water mark,
// one row at a time, as set by the eight-bit row search unit and the single read port of
// the used-bit memory. One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
// depends on lfst_pkg, lfst_scan, lfst_store
module lowest_free_slot_table_core import lfst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value[30:0], position[36:31]
  input  logic                   s_axis_tuser,   // opcode[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // slot_index[5:0], read_value[36:6]
  output logic [ST_W-1:0]        m_axis_tuser    // status[1:0]
);

  localparam int IW   = $clog2(SLOTS);
  localparam int PW   = $clog2(SLOTS + 1);
  localparam int ROWS = (SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [RW-1:0]       clr_q, clr_d;
  logic [PW-1:0]       lf_q, lf_d;
  logic [PW-1:0]       hw_q, hw_d;
  op_e                 op_q, op_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CMP_W-1:0]    base_q, base_d;
  logic [CMP_W-1:0]    start_q, start_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  logic [VALUE_W-1:0]  res_val_q, res_val_d;
  status_e             res_st_q, res_st_d;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [VALUE_W-1:0]  out_val_q, out_val_d;
  status_e             out_st_q, out_st_d;

  logic                in_acc;
  op_e                 in_op;
  logic [VALUE_W-1:0]  in_val;
  logic [POS_W-1:0]    in_pos;
  logic [CMP_W-1:0]    lf_w, hw_w, pos_w;
  logic [CMP_W-1:0]    scan_base, scan_start, scan_idx, scan_next;
  logic                scan_found, scan_last;
  logic                out_free;
  logic                pop_ok;

  mem_ctl_t            mem_ctl;
  logic [RW-1:0]       used_waddr, used_raddr;
  logic [ROW_BITS-1:0] used_wdata, used_rdata;
  logic [IW-1:0]       val_waddr, val_raddr;
  logic [VALUE_W-1:0]  val_rdata;

  assign in_op  = op_e'(s_axis_tuser);
  assign in_val = s_axis_tdata[VALUE_W-1:0];
  assign in_pos = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign lf_w  = CMP_W'(lf_q);
  assign hw_w  = CMP_W'(hw_q);
  assign pos_w = CMP_W'(pos_q);

  // first row comes straight from the accept read, later rows from the scan registers
  assign scan_base  = (state_q == S_EXEC) ? (lf_w & ~CMP_W'(ROW_BITS - 1)) : base_q;
  assign scan_start = (state_q == S_EXEC) ? (lf_w + CMP_W'(1)) : start_q;

  assign pop_ok = (pos_w < CMP_W'(SLOTS)) && used_rdata[ROW_SH'(pos_q)];

  lfst_scan u_scan (
    .used_i  (used_rdata),
    .base_i  (scan_base),
    .start_i (scan_start),
    .limit_i (hw_w),
    .found_o (scan_found),
    .idx_o   (scan_idx),
    .next_o  (scan_next),
    .last_o  (scan_last)
  );

  lfst_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .used_waddr_i (used_waddr),
    .used_wdata_i (used_wdata),
    .used_raddr_i (used_raddr),
    .used_rdata_o (used_rdata),
    .val_waddr_i  (val_waddr),
    .val_wdata_i  (val_q),
    .val_raddr_i  (val_raddr),
    .val_rdata_o  (val_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lf_d        = lf_q;
    hw_d        = hw_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    base_d      = base_q;
    start_d     = start_q;
    res_idx_d   = res_idx_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;

    mem_ctl    = '0;
    used_waddr = RW'(lf_w >> ROW_SH);
    used_wdata = used_rdata | (ROW_BITS'(1) << ROW_SH'(lf_q));
    val_waddr  = IW'(lf_q);
    val_raddr  = IW'(in_pos);
    used_raddr = RW'(scan_next >> ROW_SH);

    unique case (state_q)
      S_CLEAR: begin
        mem_ctl.used_we = 1'b1;
        used_waddr      = clr_q;
        used_wdata      = '0;
        clr_d           = clr_q + RW'(1);
        if (clr_q == RW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // read the row the item will look at
        if (in_op == OP_PUT) begin
          used_raddr = RW'(lf_w >> ROW_SH);
        end else begin
          used_raddr = RW'(CMP_W'(in_pos) >> ROW_SH);
        end
        if (in_acc) begin
          op_d    = in_op;
          val_d   = in_val;
          pos_d   = in_pos;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == OP_PUT) begin
          if (lf_w >= CMP_W'(SLOTS)) begin
            res_idx_d = '0;
            res_val_d = '0;
            res_st_d  = ST_FULL;
            state_d   = S_DONE;
          end else begin
            mem_ctl.used_we = 1'b1;
            mem_ctl.val_we  = 1'b1;
            res_idx_d       = IDX_W'(lf_q);
            res_val_d       = '0;
            res_st_d        = ST_OK;
            start_d         = scan_start;
            base_d          = scan_next;
            if (lf_q == hw_q) begin
              lf_d    = PW'(lf_w + CMP_W'(1));
              hw_d    = PW'(lf_w + CMP_W'(1));
              state_d = S_DONE;
            end else if (scan_found) begin
              lf_d    = PW'(scan_idx);
              state_d = S_DONE;
            end else if (scan_last) begin
              lf_d    = hw_q;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
        end else begin
          res_idx_d = IDX_W'(pos_q);
          res_val_d = '0;
          state_d   = S_DONE;
          if (pos_w >= CMP_W'(SLOTS)) begin
            res_st_d = ST_RANGE;
          end else if (!pop_ok) begin
            res_st_d = ST_EMPTY;
          end else begin
            mem_ctl.used_we = 1'b1;
            used_waddr      = RW'(pos_w >> ROW_SH);
            used_wdata      = used_rdata & ~(ROW_BITS'(1) << ROW_SH'(pos_q));
            res_val_d       = val_rdata;
            res_st_d        = ST_OK;
            if (lf_w > pos_w) begin
              lf_d = PW'(pos_w);
            end
            if (hw_w == pos_w + CMP_W'(1)) begin
              hw_d = PW'(pos_w);
            end
          end
        end
      end
      S_SCAN: begin
        base_d = scan_next;
        if (scan_found) begin
          lf_d    = PW'(scan_idx);
          state_d = S_DONE;
        end else if (scan_last) begin
          lf_d    = hw_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      lf_q        <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lf_q        <= lf_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    base_q    <= base_d;
    start_q   <= start_d;
    res_idx_q <= res_idx_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W - IDX_W)'(0), out_val_q, out_idx_q};
  assign m_axis_tuser  = out_st_q;

endmodule

// File: hw/rtl/lfst_checker.sv
// lfst_checker: port-level checks of the slot table, bound to the top level
// depends on lfst_pkg and lowest_free_slot_table_core
module lfst_checker import lfst_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [ST_W-1:0]        m_axis_tuser
);

  // one item in work at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // a failed operation never returns a value
  a_no_value_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[IDX_W+VALUE_W-1:IDX_W] == '0)
    else $error("value returned with error status");

  // full table reports slot zero
  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[IDX_W-1:0] == '0)
    else $error("full status with non-zero slot");

  // held result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

endmodule

bind lowest_free_slot_table_core lfst_checker u_lfst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: dv/tb.sv
// tb: self-checking testbench for lowest_free_slot_table_core, with directed and random
// put/pop beats, random idling on both streams and a scoreboard that predicts every reply
// depends on lfst_pkg and lowest_free_slot_table_core
module tb import lfst_pkg::*; ();

  localparam int SLOTS = SLOTS_DEF;
  localparam int PAD_W = IN_TDATA_W - POS_W - VALUE_W;
  localparam int RANDOM_ITEMS = 1200;
  localparam int TAIL_ITEMS = 150;

  typedef struct packed {
    logic [IDX_W-1:0]   slot;
    logic [VALUE_W-1:0] value;
    status_e            status;
  } reply_t;

  // slot table prediction and queue of replies still owed by the block
  class slot_table_scoreboard;
    logic [VALUE_W-1:0] held_value[SLOTS];
    bit                 in_use[SLOTS];
    int                 lowest_free;
    int                 high_water;
    reply_t             owed_replies[$];
    int                 errors;

    function new();
      foreach (in_use[i]) begin
        in_use[i] = 1'b0;
        held_value[i] = '0;
      end
      lowest_free = 0;
      high_water = 0;
      errors = 0;
    endfunction

    function void record_request(op_e op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
      reply_t r;
      int     slot;
      r.slot = '0;
      r.value = '0;
      r.status = ST_OK;
      if (op == OP_PUT) begin
        if (lowest_free >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot = lowest_free;
          held_value[slot] = val;
          in_use[slot] = 1'b1;
          r.slot = IDX_W'(slot);
          if (slot == high_water) begin
            lowest_free = slot + 1;
            high_water = slot + 1;
          end else begin
            lowest_free = high_water;
            for (int j = slot + 1; j < high_water && j < SLOTS; j++) begin
              if (!in_use[j]) begin
                lowest_free = j;
                break;
              end
            end
          end
        end
      end else begin
        r.slot = IDX_W'(pos);
        if (int'(pos) >= SLOTS) begin
          r.status = ST_RANGE;
        end else if (!in_use[pos]) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = held_value[pos];
          in_use[pos] = 1'b0;
          if (lowest_free > int'(pos)) lowest_free = int'(pos);
          if (high_water == int'(pos) + 1) high_water = int'(pos);
        end
      end
      owed_replies.push_back(r);
    endfunction

    function void compare_reply(logic [IDX_W-1:0] slot, logic [VALUE_W-1:0] val,
                                logic [ST_W-1:0] st);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $error("reply beat with no request waiting: slot_index %0d read_value %0h status %0d",
               slot, val, st);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (slot !== want.slot) begin
        $error("slot_index: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (val !== want.value) begin
        $error("read_value: expected %0h, got %0h", want.value, val);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // value[30:0], position[36:31]
  logic                   s_axis_tuser = 1'b0; // opcode[0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // slot_index[5:0], read_value[36:6]
  logic [ST_W-1:0]        m_axis_tuser;        // status[1:0]

  slot_table_scoreboard book = new();
  bit quiet = 1'b0;
  int stall_left = 0;

  lowest_free_slot_table_core #(.SLOTS(SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  task automatic send_item(op_e op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {PAD_W'(0), pos, val};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    book.record_request(op, val, pos);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // mostly pop a slot that holds something, now and then any position
  function automatic logic [POS_W-1:0] pick_position();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < SLOTS; k++) begin
        if (book.in_use[(start + k) % SLOTS]) return POS_W'((start + k) % SLOTS);
      end
    end
    return POS_W'($urandom);
  endfunction

  // reply side with stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        book.compare_reply(m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W+VALUE_W-1:IDX_W],
                           m_axis_tuser);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int put_pct;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pops at both ends, value extremes, gap refill, top trim
    send_item(OP_POP, '0, POS_W'(0));
    send_item(OP_POP, '0, '1);
    send_item(OP_PUT, '1, '0);
    send_item(OP_PUT, '0, '1);
    send_item(OP_PUT, VALUE_W'(32'h2aaa_aaaa), '0);
    send_item(OP_PUT, VALUE_W'(32'h5555_5555), '1);
    send_item(OP_POP, '1, POS_W'(1));
    send_item(OP_PUT, VALUE_W'(32'h0001_2345), '0);
    send_item(OP_POP, '0, POS_W'(3));
    send_item(OP_POP, '0, POS_W'(2));
    send_item(OP_POP, '0, POS_W'(2));
    send_item(OP_POP, '0, POS_W'(0));
    send_item(OP_PUT, VALUE_W'(32'h7fff_0000), POS_W'(6'h2a));
    send_item(OP_POP, '0, POS_W'(6'h15));
    send_item(OP_POP, '0, POS_W'(1));
    send_item(OP_POP, '0, POS_W'(0));

    // random phases that lean towards filling, draining or churning the table
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 200);
      case ($urandom_range(0, 2))
        0:       put_pct = 90;
        1:       put_pct = 15;
        default: put_pct = 55;
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        if (sent >= RANDOM_ITEMS - TAIL_ITEMS) quiet = 1'b1;
        if ($urandom_range(1, 100) <= put_pct)
          send_item(OP_PUT, pick_value(), POS_W'($urandom));
        else
          send_item(OP_POP, VALUE_W'($urandom), pick_position());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (book.owed_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lfst_pkg.sv
hw/rtl/lfst_scan.sv
hw/rtl/lfst_store.sv
hw/rtl/lowest_free_slot_table_core.sv
hw/rtl/lfst_checker.sv
dv/tb.sv
